@@ rtl/core/table_driven_state_machine_top_assert.svh @@
// ----------------------------------------------------------------------------
// table_driven_state_machine_top_assert
// assertion macros for the table driven state machine, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_STATE_MACHINE_TOP_ASSERT_SVH
`define TABLE_DRIVEN_STATE_MACHINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TDSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdsm assertion failed");

// next-cycle implication
`define TDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdsm assertion failed");

`else

`define TDSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/tdsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsm_pkg
// shared types and constants of the table driven state machine
// ----------------------------------------------------------------------------
`default_nettype none

package tdsm_pkg;

    localparam int FIELD_W = 4;
    localparam int REG_W   = 5;
    localparam int CNT_W   = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic REG_STATES = 1'b0;
    localparam logic REG_INPUTS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_STEP  = 2'd0,
        FUNC_ARC   = 2'd1,
        FUNC_FORCE = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_TGT  = 2'd1,
        S_ROW  = 2'd2,
        S_WB   = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] state_index;
        logic [FIELD_W-1:0] symbol;
        logic [FIELD_W-1:0] arc_target;
        logic               arc_present;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] result_state;
        logic               arc_found;
        logic [FIELD_W-1:0] present_state;
        logic               state_defined;
        logic               has_outgoing_arc;
        logic               error;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0] states_eff;
        logic [CNT_W-1:0] inputs_eff;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/tdsm_tgt_mem.sv @@
// ----------------------------------------------------------------------------
// tdsm_tgt_mem
// arc target memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_tgt_mem #(
    parameter int AW = 8
) (
    input  wire                          i_clk,
    input  wire                          i_re,
    input  wire  [AW-1:0]                i_raddr,
    input  wire                          i_we,
    input  wire  [AW-1:0]                i_waddr,
    input  wire  [tdsm_pkg::FIELD_W-1:0] i_wdata,
    output logic [tdsm_pkg::FIELD_W-1:0] o_rdata
);
    import tdsm_pkg::*;

    logic [FIELD_W-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tdsm_mask_mem.sv @@
// ----------------------------------------------------------------------------
// tdsm_mask_mem
// arc presence rows, one row per state, with a valid bit per row
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_mask_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]          o_rdata
);
    import tdsm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [DEPTH-1:0] r_vld;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    // rows never written read as empty
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

@@ rtl/core/tdsm_cfg.sv @@
// ----------------------------------------------------------------------------
// tdsm_cfg
// apb register file for state and symbol counts, with clamping
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_cfg #(
    parameter int MAX_STATES = 16,
    parameter int MAX_INPUTS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [tdsm_pkg::APB_AW-1:0] paddr,
    input  wire  [tdsm_pkg::APB_DW-1:0] pwdata,
    output logic [tdsm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output tdsm_pkg::t_cfg              o_cfg
);
    import tdsm_pkg::*;

    logic [REG_W-1:0] r_states;
    logic [REG_W-1:0] r_inputs;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states <= REG_W'(16);
            r_inputs <= REG_W'(16);
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_STATES: r_states <= pwdata[REG_W-1:0];
                REG_INPUTS: r_inputs <= pwdata[REG_W-1:0];
                default:    r_states <= r_states;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STATES: prdata = APB_DW'(r_states);
            REG_INPUTS: prdata = APB_DW'(r_inputs);
            default:    prdata = '0;
        endcase
    end

    // effective counts limited to 1..max
    always_comb begin
        if (r_states == '0) begin
            o_cfg.states_eff = CNT_W'(1);
        end else if (CNT_W'(r_states) > CNT_W'(MAX_STATES)) begin
            o_cfg.states_eff = CNT_W'(MAX_STATES);
        end else begin
            o_cfg.states_eff = CNT_W'(r_states);
        end
        if (r_inputs == '0) begin
            o_cfg.inputs_eff = CNT_W'(1);
        end else if (CNT_W'(r_inputs) > CNT_W'(MAX_INPUTS)) begin
            o_cfg.inputs_eff = CNT_W'(MAX_INPUTS);
        end else begin
            o_cfg.inputs_eff = CNT_W'(r_inputs);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tdsm_seq.sv @@
// ----------------------------------------------------------------------------
// tdsm_seq
// request sequencer: reads, modifies and writes back the transition memories
// ----------------------------------------------------------------------------
`default_nettype none

module tdsm_seq #(
    parameter int MAX_STATES = 16,
    parameter int MAX_INPUTS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire tdsm_pkg::t_cfg i_cfg,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire tdsm_pkg::t_in  i_in_req,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output tdsm_pkg::t_out      o_out_res
);
    import tdsm_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int IW = $clog2(MAX_INPUTS);
    localparam int AW = SW + IW;

    t_state                r_state, n_state;
    logic [FIELD_W-1:0]    r_cur, n_cur;
    logic                  r_def, n_def;
    logic [MAX_INPUTS-1:0] r_cur_row, n_cur_row;
    t_in                   r_req, n_req;
    logic                  r_out_vld, n_out_vld;
    t_out                  r_out, n_out;

    logic                  tgt_re, tgt_we;
    logic [AW-1:0]         tgt_raddr, tgt_waddr;
    logic [FIELD_W-1:0]    tgt_rdata;
    logic                  mask_re, mask_we;
    logic [SW-1:0]         mask_raddr, mask_waddr;
    logic [MAX_INPUTS-1:0] mask_rdata, new_row, cur_row_upd;
    logic [MAX_INPUTS-1:0] sym_mask;

    logic                  accept, slot_free;
    logic                  sidx_ok, sym_ok, tgt_ok;
    logic [SW-1:0]         sidx_ix, cur_ix;
    logic [IW-1:0]         sym_ix;

    tdsm_tgt_mem #(
        .AW(AW)
    ) u_tgt_mem (
        .i_clk  (i_clk),
        .i_re   (tgt_re),
        .i_raddr(tgt_raddr),
        .i_we   (tgt_we),
        .i_waddr(tgt_waddr),
        .i_wdata(i_in_req.arc_target),
        .o_rdata(tgt_rdata)
    );

    tdsm_mask_mem #(
        .DEPTH(MAX_STATES),
        .WIDTH(MAX_INPUTS)
    ) u_mask_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (mask_re),
        .i_raddr(mask_raddr),
        .i_we   (mask_we),
        .i_waddr(mask_waddr),
        .i_wdata(new_row),
        .o_rdata(mask_rdata)
    );

    assign slot_free  = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_vld && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign sidx_ix = SW'(i_in_req.state_index);
    assign sym_ix  = IW'(i_in_req.symbol);
    assign cur_ix  = SW'(r_cur);

    assign sidx_ok = CNT_W'(i_in_req.state_index) < i_cfg.states_eff;
    assign sym_ok  = CNT_W'(i_in_req.symbol) < i_cfg.inputs_eff;
    assign tgt_ok  = CNT_W'(i_in_req.arc_target) < i_cfg.states_eff;

    // symbols in use
    always_comb begin
        for (int k = 0; k < MAX_INPUTS; k++) begin
            sym_mask[k] = CNT_W'(k) < i_cfg.inputs_eff;
        end
    end

    // row after the arc update, and the current row seen through it
    always_comb begin
        new_row = mask_rdata;
        new_row[IW'(r_req.symbol)] = r_req.arc_present;
        if (r_def && (r_cur == r_req.state_index)) begin
            cur_row_upd = new_row;
        end else begin
            cur_row_upd = r_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_def     <= 1'b0;
            r_cur_row <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_def     <= n_def;
            r_cur_row <= n_cur_row;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_def      = r_def;
        n_cur_row  = r_cur_row;
        n_req      = r_req;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out      = r_out;
        tgt_re     = 1'b0;
        tgt_we     = 1'b0;
        tgt_raddr  = {cur_ix, sym_ix};
        tgt_waddr  = {sidx_ix, sym_ix};
        mask_re    = 1'b0;
        mask_we    = 1'b0;
        mask_raddr = sidx_ix;
        mask_waddr = SW'(r_req.state_index);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req     = i_in_req;
                    // immediate result unless a memory access follows
                    n_out_vld = 1'b1;
                    n_out.result_state     = '0;
                    n_out.arc_found        = 1'b0;
                    n_out.present_state    = r_def ? r_cur : '0;
                    n_out.state_defined    = r_def;
                    n_out.has_outgoing_arc = r_def && |(r_cur_row & sym_mask);
                    n_out.error            = 1'b0;
                    unique case (t_func'(i_in_req.func))
                        FUNC_STEP: begin
                            if (!sym_ok) begin
                                n_out.error = 1'b1;
                            end else if (r_def && r_cur_row[sym_ix]) begin
                                tgt_re    = 1'b1;
                                n_out_vld = 1'b0;
                                n_state   = S_TGT;
                            end
                        end
                        FUNC_ARC: begin
                            if (!sidx_ok || !sym_ok ||
                                (i_in_req.arc_present && !tgt_ok)) begin
                                n_out.error = 1'b1;
                            end else begin
                                tgt_we    = i_in_req.arc_present;
                                mask_re   = 1'b1;
                                n_out_vld = 1'b0;
                                n_state   = S_WB;
                            end
                        end
                        FUNC_FORCE: begin
                            if (!sidx_ok) begin
                                n_out.error = 1'b1;
                            end else begin
                                n_cur     = i_in_req.state_index;
                                n_def     = 1'b1;
                                mask_re   = 1'b1;
                                n_out_vld = 1'b0;
                                n_state   = S_ROW;
                            end
                        end
                        FUNC_QUERY: begin
                            n_out.error = 1'b0;
                        end
                        default: begin
                            n_out.error = 1'b0;
                        end
                    endcase
                end
            end
            S_TGT: begin
                n_cur      = tgt_rdata;
                mask_re    = 1'b1;
                mask_raddr = SW'(tgt_rdata);
                n_state    = S_ROW;
            end
            S_ROW: begin
                if (slot_free) begin
                    n_cur_row              = mask_rdata;
                    n_out_vld              = 1'b1;
                    n_out.result_state     = r_cur;
                    n_out.arc_found        = t_func'(r_req.func) == FUNC_STEP;
                    n_out.present_state    = r_cur;
                    n_out.state_defined    = 1'b1;
                    n_out.has_outgoing_arc = |(mask_rdata & sym_mask);
                    n_out.error            = 1'b0;
                    n_state                = S_IDLE;
                end
            end
            S_WB: begin
                if (slot_free) begin
                    mask_we                = 1'b1;
                    n_cur_row              = cur_row_upd;
                    n_out_vld              = 1'b1;
                    n_out.result_state     = r_req.arc_present ? r_req.arc_target : '0;
                    n_out.arc_found        = r_req.arc_present;
                    n_out.present_state    = r_def ? r_cur : '0;
                    n_out.state_defined    = r_def;
                    n_out.has_outgoing_arc = r_def && |(cur_row_upd & sym_mask);
                    n_out.error            = 1'b0;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

endmodule

`default_nettype wire

@@ rtl/core/table_driven_state_machine_top.sv @@
// ----------------------------------------------------------------------------
// table_driven_state_machine_top
// programmable transition table state machine with apb configuration
// ----------------------------------------------------------------------------
// requests enter on i_in_valid / o_in_stall with payload i_in_req; each
// request gives exactly one result on o_out_valid / i_out_stall, payload
// o_out_res. a request is taken when valid is high and stall is low.
// a query, a rejected request or a step with no arc has its result
// registered from idle; an arc write passes through S_WB, a forced state
// through S_ROW, and a step that finds an arc through S_TGT, then S_ROW.
// a step reads the target memory and then the presence row of the new
// state, both synchronous reads, so one request is in flight at a time
// and the next is taken once its result sits in the output register.
// the output register holds a result while i_out_stall is high; a new
// request may still be taken then only if the output slot frees up.
// the apb port sets the number of states and symbols in use; write it only
// while no request is in flight.
// reset (i_rst_n low, synchronous) clears all presence rows through their
// valid bits, leaves no current state and restores both counts to 16; no
// clearing pass is needed, requests are taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_driven_state_machine_top_assert.svh"

module table_driven_state_machine_top #(
    parameter int MAX_STATES = 16,
    parameter int MAX_INPUTS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [tdsm_pkg::APB_AW-1:0] paddr,
    input  wire  [tdsm_pkg::APB_DW-1:0] pwdata,
    output logic [tdsm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire tdsm_pkg::t_in          i_in_req,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output tdsm_pkg::t_out              o_out_res
);
    import tdsm_pkg::*;

    t_cfg cfg;

    tdsm_cfg #(
        .MAX_STATES(MAX_STATES),
        .MAX_INPUTS(MAX_INPUTS)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    tdsm_seq #(
        .MAX_STATES(MAX_STATES),
        .MAX_INPUTS(MAX_INPUTS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

    `TDSM_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_out_valid && o_out_res.error, (o_out_res.result_state == '0) && !o_out_res.arc_found)
    `TDSM_ASSERT_IMPL(a_undef_quiet, i_clk, i_rst_n, o_out_valid && !o_out_res.state_defined, (o_out_res.present_state == '0) && !o_out_res.has_outgoing_arc)
    `TDSM_ASSERT_NEXT(a_busy_after_walk, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_req.func != FUNC_QUERY) && !o_out_valid, o_in_stall || o_out_valid)

endmodule

`default_nettype wire
